// ===== hdl/lifo_stack_with_search_macros.svh =====
// ----------------------------------------------------------------------------
// lifo_stack_with_search_macros.svh
// Assertion helpers used by the stack top-level file.
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_WITH_SEARCH_MACROS_SVH
`define LIFO_STACK_WITH_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted
`define LSS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted
`define LSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// lss_pkg
// Shared widths, codes and controller/datapath link types for the stack.
// ----------------------------------------------------------------------------
package lss_pkg;

    // Default number of entries
    localparam int LSS_DEPTH = 256;

    // Fixed field widths
    localparam int CMD_W  = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int IDX_W  = 8;
    localparam int FILL_W = 9;
    localparam int CAP_W  = 9;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // Command codes
    localparam logic [CMD_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] OP_POP    = 3'd1;
    localparam logic [CMD_W-1:0] OP_PEEK   = 3'd2;
    localparam logic [CMD_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] OP_SEARCH = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } lss_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic start;     // take the request and do its first access
        logic step;      // compare one entry of a search
        logic load_out;  // move the finished result into the output register
    } lss_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_start; // request is a search on a non-empty stack
        logic hit;        // entry under compare matches
        logic scan_last;  // entry under compare is the bottom one
    } lss_sts_t;

endpackage

// ===== hdl/lss_req_if.sv =====
// ----------------------------------------------------------------------------
// lss_req_if
// Request channel: command and value with valid/ready.
// ----------------------------------------------------------------------------
interface lss_req_if import lss_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);

endinterface

// ===== hdl/lss_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lss_rsp_if
// Result channel: status, data, found index and fill count with valid/ready.
// ----------------------------------------------------------------------------
interface lss_rsp_if import lss_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data;
    logic [IDX_W-1:0]         found_index;
    logic [FILL_W-1:0]        fill_count;

    modport source (output valid, output status, output data, output found_index,
                    output fill_count, input ready);
    modport sink   (input valid, input status, input data, input found_index,
                    input fill_count, output ready);

endinterface

// ===== hdl/lss_ctrl.sv =====
// ----------------------------------------------------------------------------
// lss_ctrl
// Sequencer: takes a request, runs the search scan, hands off the result.
// ----------------------------------------------------------------------------
module lss_ctrl import lss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  lss_sts_t sts,
    output lss_cmd_t cmd
);

    lss_state_t state_reg;
    lss_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.scan_start ? S_SEARCH : S_FINISH;
                end
            end
            S_SEARCH:
            begin
                if (sts.hit || sts.scan_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cmd.start    = 1'b0;
        cmd.step     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            S_SEARCH:
            begin
                cmd.step = 1'b1;
            end
            S_FINISH:
            begin
                cmd.load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Hold the result valid until taken; reload keeps it up
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/lss_dp.sv =====
// ----------------------------------------------------------------------------
// lss_dp
// Datapath: entry memory, top pointer, capacity, scan counter, result regs.
// ----------------------------------------------------------------------------
module lss_dp import lss_pkg::*;
#(
    parameter int DEPTH = LSS_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CAP_W-1:0]         cfg_wdata,
    input  logic [CMD_W-1:0]         in_command,
    input  logic signed [DATA_W-1:0] in_value,
    input  lss_cmd_t                 cmd,
    output lss_sts_t                 sts,
    output logic [STAT_W-1:0]        out_status,
    output logic signed [DATA_W-1:0] out_data,
    output logic [IDX_W-1:0]         out_found_index,
    output logic [FILL_W-1:0]        out_fill_count
);

    localparam int PTR_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = (PTR_W > CAP_W) ? PTR_W : CAP_W;
    localparam int FW     = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

    logic signed [DATA_W-1:0] mem [DEPTH];

    logic [CAP_W-1:0]         capacity_reg;
    logic [PTR_W-1:0]         top_reg;
    logic [PTR_W-1:0]         top_next;
    logic [CMD_W-1:0]         op_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [STAT_W-1:0]        st_reg;
    logic [STAT_W-1:0]        st_next;
    logic [ADDR_W-1:0]        scan_reg;
    logic [ADDR_W-1:0]        scan_next;
    logic [ADDR_W-1:0]        found_reg;
    logic signed [DATA_W-1:0] rd_data_reg;

    logic [CW-1:0]            cap_ext;
    logic [CW-1:0]            limit;
    logic [CW-1:0]            top_ext;
    logic [FW-1:0]            found_ext;
    logic [PTR_W-1:0]         top_dec;
    logic                     is_empty;
    logic                     is_full;
    logic                     mem_we;
    logic                     mem_re;
    logic [ADDR_W-1:0]        mem_raddr;

    // Usable limit is the capacity saturated at the depth
    assign cap_ext  = CW'(capacity_reg);
    assign limit    = (cap_ext > CW'(DEPTH)) ? CW'(DEPTH) : cap_ext;
    assign top_ext  = CW'(top_reg);
    assign top_dec  = top_reg - PTR_W'(1);
    assign is_empty = (top_reg == '0);
    assign is_full  = (top_ext >= limit);

    // Status toward the controller
    assign sts.scan_start = (in_command == OP_SEARCH) && !is_empty;
    assign sts.hit        = (rd_data_reg == val_reg);
    assign sts.scan_last  = (scan_reg == '0);

    // Decode memory accesses
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = top_dec[ADDR_W-1:0];
        if (cmd.start)
        begin
            mem_we = (in_command == OP_PUSH) && !is_full;
            mem_re = (in_command == OP_POP) || (in_command == OP_PEEK)
                     || (in_command == OP_SEARCH);
        end
        else if (cmd.step && !sts.hit && !sts.scan_last)
        begin
            mem_re    = 1'b1;
            mem_raddr = scan_reg - ADDR_W'(1);
        end
    end

    // Pointer, status and scan updates
    always_comb
    begin
        top_next  = top_reg;
        st_next   = st_reg;
        scan_next = scan_reg;
        if (cmd.start)
        begin
            st_next   = STAT_OK;
            scan_next = top_dec[ADDR_W-1:0];
            case (in_command)
                OP_PUSH:
                begin
                    if (is_full)
                    begin
                        st_next = STAT_FULL;
                    end
                    else
                    begin
                        top_next = top_reg + PTR_W'(1);
                    end
                end
                OP_POP:
                begin
                    if (is_empty)
                    begin
                        st_next = STAT_EMPTY;
                    end
                    else
                    begin
                        top_next = top_dec;
                    end
                end
                OP_PEEK:
                begin
                    if (is_empty)
                    begin
                        st_next = STAT_EMPTY;
                    end
                end
                OP_CLEAR:
                begin
                    top_next = '0;
                end
                OP_SEARCH:
                begin
                    if (is_empty)
                    begin
                        st_next = STAT_NOTFOUND;
                    end
                end
                default:
                begin
                    st_next = STAT_OK;
                end
            endcase
        end
        else if (cmd.step)
        begin
            if (sts.hit)
            begin
                st_next = STAT_OK;
            end
            else if (sts.scan_last)
            begin
                st_next = STAT_NOTFOUND;
            end
            else
            begin
                scan_next = scan_reg - ADDR_W'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            top_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            top_reg <= top_next;
        end
    end

    // Request and scan payload
    always_ff @(posedge clk)
    begin
        st_reg   <= st_next;
        scan_reg <= scan_next;
        if (cmd.start)
        begin
            op_reg  <= in_command;
            val_reg <= in_value;
        end
        if (cmd.step && sts.hit)
        begin
            found_reg <= scan_reg;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[top_reg[ADDR_W-1:0]] <= in_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Output register
    assign found_ext = FW'(found_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status     <= st_reg;
            out_fill_count <= top_ext[FILL_W-1:0];
            if (((op_reg == OP_POP) || (op_reg == OP_PEEK)) && (st_reg == STAT_OK))
            begin
                out_data <= rd_data_reg;
            end
            else
            begin
                out_data <= '0;
            end
            if ((op_reg == OP_SEARCH) && (st_reg == STAT_OK))
            begin
                out_found_index <= found_ext[IDX_W-1:0];
            end
            else
            begin
                out_found_index <= '0;
            end
        end
    end

endmodule

// ===== hdl/lifo_stack_with_search.sv =====
// Timing: push, pop, peek, clear and unknown commands pass from the idle state through
//   the finish state into the output register once accepted; a search first passes
//   through the search state, comparing entries (one per cycle, up to DEPTH).
// Flow: the finish state waits while an earlier result is not yet taken; a new request is
//   taken only in the idle state, so one result may wait in the output register meanwhile.
// Reset: stack empty, capacity 256; entry memory is not cleared (no clearing pass).
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// Stack of signed 32-bit words with push, pop, peek, clear and top-down search.
// ----------------------------------------------------------------------------
`include "lifo_stack_with_search_macros.svh"

module lifo_stack_with_search import lss_pkg::*;
#(
    parameter int DEPTH = LSS_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    lss_req_if.sink          request,
    lss_rsp_if.source        result
);

    lss_cmd_t cmd;
    lss_sts_t sts;

    // Sequencer
    lss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Storage and result logic
    lss_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_command      (request.command),
        .in_value        (request.value),
        .cmd             (cmd),
        .sts             (sts),
        .out_status      (result.status),
        .out_data        (result.data),
        .out_found_index (result.found_index),
        .out_fill_count  (result.fill_count)
    );

    // Checks
    `LSS_ASSERT_SAME(a_start_not_with_load, cmd.start, !cmd.load_out, "request during hand-off")
    `LSS_ASSERT_SAME(a_scan_blocks_request, cmd.step, !request.ready, "ready during scan")
    `LSS_ASSERT_NEXT(a_load_raises_valid, cmd.load_out, result.valid, "no valid after load")

endmodule
